FILE: hdl/pida_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the positional insert/delete array.
// No dependencies; used by pida_cell and positional_insert_delete_array.
package pida_pkg;

  localparam int DataW = 32;

  typedef logic [DataW-1:0] data_t;

  // Operation codes of the opcode field
  localparam logic [1:0] OP_INSERT     = 2'd0;
  localparam logic [1:0] OP_DEL_FIRST  = 2'd1;
  localparam logic [1:0] OP_DEL_MIDDLE = 2'd2;
  localparam logic [1:0] OP_DEL_LAST   = 2'd3;

  // Status codes of the result
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_BADPOS    = 2'd2;
  localparam logic [1:0] ST_UNDERFLOW = 2'd3;

  // Per-cell control for one transaction
  typedef struct packed {
    logic en;     // a transaction is accepted this cycle
    logic ins;    // successful insert
    logic del;    // successful delete
    logic at;     // this cell is the target index
    logic after;  // this cell lies above the target index
  } cell_ctrl_t;

endpackage

FILE: hdl/pida_cell.sv
`timescale 1ns / 1ps
// One storage cell of the insert/delete chain.
// Depends on pida_pkg for data_t and cell_ctrl_t.
module pida_cell (
  input  logic                clk,
  input  pida_pkg::cell_ctrl_t ctrl,
  input  pida_pkg::data_t     ins_value,
  input  pida_pkg::data_t     left_data,
  input  pida_pkg::data_t     right_data,
  output pida_pkg::data_t     data,
  output pida_pkg::data_t     tap
);

  always_ff @(posedge clk) begin
    // shift up on insert, down on delete, otherwise hold
    if (ctrl.ins) begin
      if (ctrl.at) begin
        data <= ins_value;
      end else if (ctrl.after) begin
        data <= left_data;
      end
    end else if (ctrl.del && (ctrl.at || ctrl.after)) begin
      data <= right_data;
    end
    // capture the element being removed, zero elsewhere
    if (ctrl.en) begin
      tap <= (ctrl.del && ctrl.at) ? data : '0;
    end
  end

endmodule

FILE: hdl/positional_insert_delete_array.sv
`timescale 1ns / 1ps
// Top level of the positional insert/delete array: a row of pida_cell storage
// cells with decode, count register and a result output register.
// Depends on pida_pkg and pida_cell.
//
//   channel | handshake           | payload
//   --------+---------------------+---------------------------------------------
//   input   | in_valid / in_ready | opcode, position, value
//   output  | out_valid/out_ready | status, removed_value, removed_index,
//           |                     | element_count
//
// Flow: the accepting edge shifts the cell row and captures the removed
// element in the cell taps; once the output register is free it gathers the
// result from the taps and the middle stage and offers it. One transaction per
// cycle is sustained while out_ready stays high; the whole row shifts at once,
// so CAPACITY does not change the rate.
// Reset (rst, synchronous): empties the store and drops any pending result.
// Stalls: in_ready falls only while a finished result waits in the middle stage
// and the output register is still held by out_ready low.
module positional_insert_delete_array #(
  parameter int CAPACITY = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         opcode,
  input  logic [5:0]         position,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic signed [31:0] removed_value,
  output logic [4:0]         removed_index,
  output logic [5:0]         element_count
);

  localparam int CW = $clog2(CAPACITY + 1);  // count width
  localparam int IW = $clog2(CAPACITY);      // cell index width
  localparam int XW = (CW > 6) ? CW : 6;     // compare width for position

  // Element count and pipeline control
  logic [CW-1:0] count;
  logic          pending;

  // Middle stage holds everything but the removed value, which sits in the taps
  logic [1:0]    mid_status;
  logic [CW-1:0] mid_index;
  logic [CW-1:0] mid_count;

  logic accept;
  logic move;
  logic out_free;

  // Decode of the incoming transaction
  logic [XW-1:0] pos_x;
  logic [XW-1:0] cnt_x;
  logic [1:0]    dec_status;
  logic [CW-1:0] dec_index;
  logic [CW-1:0] count_next;
  logic          dec_ins;
  logic          dec_del;
  logic [IW-1:0] target;

  pida_pkg::cell_ctrl_t ctrl [CAPACITY];
  pida_pkg::data_t      cell_data [CAPACITY];
  pida_pkg::data_t      cell_tap [CAPACITY];
  pida_pkg::data_t      tap_or;

  assign out_free = !out_valid || out_ready;
  assign move     = pending && out_free;
  assign in_ready = !pending || out_free;
  assign accept   = in_valid && in_ready;

  assign pos_x = XW'(position);
  assign cnt_x = XW'(count);

  always_comb begin
    dec_status = pida_pkg::ST_OK;
    dec_index  = '0;
    dec_ins    = 1'b0;
    dec_del    = 1'b0;
    count_next = count;
    unique case (opcode)
      pida_pkg::OP_INSERT: begin
        // full store wins over a bad position
        if (count >= CW'(CAPACITY)) begin
          dec_status = pida_pkg::ST_OVERFLOW;
        end else if (pos_x > cnt_x) begin
          dec_status = pida_pkg::ST_BADPOS;
        end else begin
          dec_ins    = 1'b1;
          dec_index  = CW'(pos_x);
          count_next = count + CW'(1);
        end
      end
      pida_pkg::OP_DEL_FIRST, pida_pkg::OP_DEL_MIDDLE, pida_pkg::OP_DEL_LAST: begin
        if (count == '0) begin
          dec_status = pida_pkg::ST_UNDERFLOW;
        end else begin
          dec_del    = 1'b1;
          count_next = count - CW'(1);
          if (opcode == pida_pkg::OP_DEL_MIDDLE) begin
            // lower middle: (count-1)/2
            dec_index = (count - CW'(1)) >> 1;
          end else if (opcode == pida_pkg::OP_DEL_LAST) begin
            dec_index = count - CW'(1);
          end
        end
      end
      default: dec_status = pida_pkg::ST_OK;
    endcase
  end

  assign target = IW'(dec_index);

  // Cell row: broadcast the operation, each cell compares against its place
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    pida_pkg::data_t left_d;
    pida_pkg::data_t right_d;

    always_comb begin
      ctrl[i].en    = accept;
      ctrl[i].ins   = accept && dec_ins;
      ctrl[i].del   = accept && dec_del;
      ctrl[i].at    = (target == IW'(i));
      ctrl[i].after = (target < IW'(i));
    end

    if (i == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid_left
      assign left_d = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_mid_right
      assign right_d = cell_data[i+1];
    end

    pida_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl[i]),
      .ins_value  (pida_pkg::data_t'(value)),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (cell_data[i]),
      .tap        (cell_tap[i])
    );
  end

  // Only the removed cell has a nonzero tap, so an OR gathers it
  always_comb begin
    tap_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      tap_or = tap_or | cell_tap[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      pending   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // advance the middle stage; a new transaction refills it
      if (accept) begin
        count   <= count_next;
        pending <= 1'b1;
      end else if (move) begin
        pending <= 1'b0;
      end
      if (move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      mid_status <= dec_status;
      mid_index  <= dec_index;
      mid_count  <= count_next;
    end
    if (move) begin
      status        <= mid_status;
      removed_value <= $signed(tap_or);
      removed_index <= 5'(mid_index);
      element_count <= 6'(mid_count);
    end
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// Testbench for positional_insert_delete_array: drives insert and delete
// transactions with random idling on both channels and checks every result
// against a shadow copy of the element list. Depends on pida_pkg and the RTL.
module tb;

  localparam int Capacity  = 32;
  localparam int IdleLimit = 1000;  // cycles without any transaction before giving up
  localparam int LongHold  = 60;    // receiver hold-off that backs the block up
  localparam int ShowLimit = 10;

  // One result as the block reports it
  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] removed_value;
    logic [4:0]  removed_index;
    logic [5:0]  element_count;
  } list_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         opcode = pida_pkg::OP_INSERT;
  logic [5:0]         position = '0;
  logic signed [31:0] value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         status;
  logic signed [31:0] removed_value;
  logic [4:0]         removed_index;
  logic [5:0]         element_count;

  // Shadow copy of the list; entries at or above shadow_count are never read
  logic [31:0]  shadow_store [Capacity];
  int           shadow_count = 0;
  list_result_t pending_results [$];

  // Idling control shared by the sender, the receiver and the test tasks
  bit quiet = 1'b0;        // both sides run back to back while set
  int hold_cycles = 0;     // one-shot long hold-off for the receiver

  int mismatch_count = 0;
  int unexpected_count = 0;
  int idle_cycles = 0;
  int op_seen [4] = '{0, 0, 0, 0};
  int status_seen [4] = '{0, 0, 0, 0};

  positional_insert_delete_array #(
    .CAPACITY(Capacity)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .opcode       (opcode),
    .position     (position),
    .value        (value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .removed_value(removed_value),
    .removed_index(removed_index),
    .element_count(element_count)
  );

  always #4 clk = ~clk;

  // Apply one operation to the shadow list and return the result it must give.
  // A failed operation leaves the list untouched.
  function automatic list_result_t apply_list_op(input logic [1:0] op,
                                                 input logic [5:0] pos,
                                                 input logic [31:0] val);
    list_result_t r;
    int idx;
    int i;
    r = '0;
    if (op == pida_pkg::OP_INSERT) begin
      if (shadow_count >= Capacity) begin
        r.status = pida_pkg::ST_OVERFLOW;  // full store wins over a bad position
      end else if (int'(pos) > shadow_count) begin
        r.status = pida_pkg::ST_BADPOS;
      end else begin
        // open a gap at pos by moving the tail up one place
        for (i = shadow_count; i > int'(pos); i--) shadow_store[i] = shadow_store[i-1];
        shadow_store[pos] = val;
        shadow_count++;
        r.status = pida_pkg::ST_OK;
        r.removed_index = pos[4:0];
      end
    end else if (shadow_count == 0) begin
      r.status = pida_pkg::ST_UNDERFLOW;
    end else begin
      case (op)
        pida_pkg::OP_DEL_FIRST:  idx = 0;
        pida_pkg::OP_DEL_MIDDLE: idx = (shadow_count - 1) / 2;  // lower middle
        default:                 idx = shadow_count - 1;
      endcase
      r.removed_value = shadow_store[idx];
      // close the gap by moving the tail down one place
      for (i = idx; i < shadow_count - 1; i++) shadow_store[i] = shadow_store[i+1];
      shadow_count--;
      r.status = pida_pkg::ST_OK;
      r.removed_index = idx[4:0];
    end
    r.element_count = shadow_count[5:0];
    return r;
  endfunction

  // Offer one transaction after a random gap, hold it until accepted, then
  // queue the result it must produce. Valid stays high across back-to-back
  // transactions so it is never lowered and raised in the same step.
  task automatic send_op(input logic [1:0] op, input logic [5:0] pos,
                         input logic [31:0] val);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    position <= pos;
    value    <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(apply_list_op(op, pos, val));
    op_seen[op]++;
  endtask

  // Drop valid and wait until every queued result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Values lean on the signed extremes now and then.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 15))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'hffff_ffff;
      3:       return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Mostly legal positions, sometimes anything the 6-bit field can carry.
  function automatic logic [5:0] pick_position();
    if ($urandom_range(0, 9) < 8) return 6'($urandom_range(0, shadow_count));
    return 6'($urandom_range(0, 63));
  endfunction

  // Random operation, biased so the list keeps moving between empty and full.
  task automatic send_random_op();
    int ins_pct;
    logic [1:0] op;
    if (shadow_count < 4) ins_pct = 75;
    else if (shadow_count > Capacity - 4) ins_pct = 30;
    else ins_pct = 52;
    if ($urandom_range(0, 99) < ins_pct) op = pida_pkg::OP_INSERT;
    else op = 2'($urandom_range(1, 3));
    send_op(op, pick_position(), pick_value());
  endtask

  // Corner cases: empty deletes, bad positions, front/middle/back inserts,
  // lower middle for odd and even counts, last element removed.
  task automatic test_directed();
    send_op(pida_pkg::OP_DEL_FIRST, 6'd0, 32'd0);
    send_op(pida_pkg::OP_DEL_MIDDLE, 6'd0, 32'd0);
    send_op(pida_pkg::OP_DEL_LAST, 6'd0, 32'd0);
    send_op(pida_pkg::OP_INSERT, 6'd1, 32'h1111_1111);   // position past an empty list
    send_op(pida_pkg::OP_INSERT, 6'd63, 32'hffff_ffff);
    send_op(pida_pkg::OP_INSERT, 6'd0, 32'h8000_0000);
    send_op(pida_pkg::OP_INSERT, 6'd1, 32'h7fff_ffff);   // append
    send_op(pida_pkg::OP_INSERT, 6'd0, 32'hffff_ffff);   // push to the front
    send_op(pida_pkg::OP_INSERT, 6'd3, 32'h0000_0000);
    send_op(pida_pkg::OP_INSERT, 6'd2, 32'h1234_5678);   // land in the middle
    send_op(pida_pkg::OP_INSERT, 6'd6, 32'hdead_beef);   // one past count
    send_op(pida_pkg::OP_DEL_MIDDLE, 6'd0, 32'd0);       // odd count
    send_op(pida_pkg::OP_DEL_MIDDLE, 6'd63, 32'hffff_ffff);  // even count, ignored fields
    send_op(pida_pkg::OP_DEL_FIRST, 6'd0, 32'd0);
    send_op(pida_pkg::OP_DEL_LAST, 6'd0, 32'd0);
    send_op(pida_pkg::OP_DEL_MIDDLE, 6'd0, 32'd0);       // single element
    send_op(pida_pkg::OP_DEL_LAST, 6'd0, 32'd0);
    send_op(pida_pkg::OP_INSERT, 6'd0, 32'h5a5a_5a5a);
    wait_drained();
  endtask

  // Fill to capacity, hit overflow with both legal and illegal positions,
  // then drain with random deletes until underflow.
  task automatic test_fill_and_drain();
    while (shadow_count < Capacity)
      send_op(pida_pkg::OP_INSERT, 6'($urandom_range(0, shadow_count)), pick_value());
    send_op(pida_pkg::OP_INSERT, 6'd63, pick_value());
    send_op(pida_pkg::OP_INSERT, 6'd0, pick_value());
    send_op(pida_pkg::OP_INSERT, 6'($urandom_range(0, 63)), pick_value());
    while (shadow_count > 0)
      send_op(2'($urandom_range(1, 3)), 6'($urandom_range(0, 63)), $urandom);
    send_op(2'($urandom_range(1, 3)), 6'd0, 32'd0);
  endtask

  // Long random mix; every few hundred transactions run a back-to-back stretch.
  task automatic test_random_mix(input int count);
    int k;
    for (k = 0; k < count; k++) begin
      quiet = (k % 250) >= 200;
      send_random_op();
    end
    quiet = 1'b0;
  endtask

  // Hold the receiver off while the sender keeps pushing, so the pipeline
  // fills and in_ready drops.
  task automatic test_output_stall();
    int k;
    wait_drained();
    hold_cycles = LongHold;
    quiet = 1'b1;
    for (k = 0; k < 40; k++) send_random_op();
    quiet = 1'b0;
  endtask

  // Pause the sender until the block has answered everything, then resume.
  task automatic test_pause_until_drained();
    int k;
    for (k = 0; k < 20; k++) send_random_op();
    wait_drained();
    for (k = 0; k < 20; k++) send_random_op();
  endtask

  // Receiver: draw a stall per result, honor a pending long hold-off, and
  // check each accepted result against the oldest expectation.
  initial begin
    int stall;
    list_result_t got;
    list_result_t want;
    while (rst) @(posedge clk);
    forever begin
      stall = hold_cycles + (quiet ? 0 : $urandom_range(0, 3));
      hold_cycles = 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      got = '{status, removed_value, removed_index, element_count};
      status_seen[status]++;
      if (pending_results.size() == 0) begin
        unexpected_count++;
        if (unexpected_count + mismatch_count <= ShowLimit)
          $display("[%0t] result with nothing expected: status %0d value %h index %0d count %0d",
                   $realtime, got.status, got.removed_value, got.removed_index,
                   got.element_count);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (unexpected_count + mismatch_count <= ShowLimit)
            $display("[%0t] mismatch: exp status %0d value %h index %0d count %0d, %s",
                     $realtime, want.status, want.removed_value, want.removed_index,
                     want.element_count,
                     $sformatf("got status %0d value %h index %0d count %0d",
                               got.status, got.removed_value, got.removed_index,
                               got.element_count));
        end
      end
    end
  end

  // Watchdog: any cycle with a transaction on either channel resets the count.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("[%0t] no transaction for %0d cycles", $realtime, IdleLimit);
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_fill_and_drain();
    test_random_mix(600);
    test_output_stall();
    test_pause_until_drained();
    quiet = 1'b1;
    test_fill_and_drain();
    quiet = 1'b0;
    test_random_mix(1000);

    // Let the pipeline settle so any stray result still shows up.
    wait_drained();
    repeat (8) @(posedge clk);

    $display("Ran %0d inserts and %0d/%0d/%0d first/middle/last deletes.",
             op_seen[pida_pkg::OP_INSERT], op_seen[pida_pkg::OP_DEL_FIRST],
             op_seen[pida_pkg::OP_DEL_MIDDLE], op_seen[pida_pkg::OP_DEL_LAST]);
    $display("Results: %0d ok, %0d overflow, %0d bad position, %0d underflow; %0d errors.",
             status_seen[pida_pkg::ST_OK], status_seen[pida_pkg::ST_OVERFLOW],
             status_seen[pida_pkg::ST_BADPOS], status_seen[pida_pkg::ST_UNDERFLOW],
             mismatch_count + unexpected_count);
    if (mismatch_count == 0 && unexpected_count == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
